/* rtl/tle_pkg.sv */
package tle_pkg;

   // Default line capacity in characters
   localparam int unsigned LINE_MAX_DEF = 256;

   // Key bytes the editor recognises
   localparam logic [7:0] KEY_CTRL_A = 8'h01;
   localparam logic [7:0] KEY_CTRL_E = 8'h05;
   localparam logic [7:0] KEY_BS     = 8'h08;
   localparam logic [7:0] KEY_NL     = 8'h0a;
   localparam logic [7:0] KEY_CTRL_K = 8'h0b;
   localparam logic [7:0] KEY_ESC    = 8'h1b;
   localparam logic [7:0] KEY_DIGIT3 = 8'h33;
   localparam logic [7:0] KEY_UP_C   = 8'h43;
   localparam logic [7:0] KEY_UP_D   = 8'h44;
   localparam logic [7:0] KEY_UP_F   = 8'h46;
   localparam logic [7:0] KEY_UP_H   = 8'h48;
   localparam logic [7:0] KEY_LBR    = 8'h5b;
   localparam logic [7:0] KEY_TILDE  = 8'h7e;
   localparam logic [7:0] KEY_DEL    = 8'h7f;

   // Key classes handed from datapath to controller
   localparam logic [3:0] KC_OTHER  = 4'd0;
   localparam logic [3:0] KC_BS     = 4'd1;
   localparam logic [3:0] KC_ESC    = 4'd2;
   localparam logic [3:0] KC_CTRL_A = 4'd3;
   localparam logic [3:0] KC_CTRL_E = 4'd4;
   localparam logic [3:0] KC_CTRL_K = 4'd5;
   localparam logic [3:0] KC_NL     = 4'd6;
   localparam logic [3:0] KC_LBR    = 4'd7;
   localparam logic [3:0] KC_DIGIT3 = 4'd8;
   localparam logic [3:0] KC_TILDE  = 4'd9;
   localparam logic [3:0] KC_RIGHT  = 4'd10;
   localparam logic [3:0] KC_LEFT   = 4'd11;
   localparam logic [3:0] KC_END    = 4'd12;
   localparam logic [3:0] KC_HOME   = 4'd13;

   typedef struct packed {
      logic       mode;
      logic [7:0] key_byte;
      logic [7:0] read_index;
   } req_type;

   typedef struct packed {
      logic [8:0] cursor_pos;
      logic [8:0] line_length;
      logic       line_done;
      logic       char_dropped;
      logic [7:0] read_char;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic clear_line;
      logic rd_index;
      logic latch_char;
      logic cur_inc;
      logic cur_dec;
      logic cur_home;
      logic cur_end;
      logic len_cut;
      logic len_dec;
      logic ptr_from_cur;
      logic ptr_from_cur_m1;
      logic ptr_from_len;
      logic shl_step;
      logic shr_step;
      logic put_key;
      logic set_done;
      logic set_dropped;
      logic respond;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic       mode;
      logic [3:0] kclass;
      logic       cur_lt_len;
      logic       cur_nz;
      logic       len_lt_max;
      logic       shl_more;
      logic       shr_more;
   } sts_type;

   function automatic logic [3:0] key_class(input logic [7:0] key);
      logic [3:0] kc;
      unique case (key) inside
         KEY_BS, KEY_DEL: kc = KC_BS;
         KEY_ESC:         kc = KC_ESC;
         KEY_CTRL_A:      kc = KC_CTRL_A;
         KEY_CTRL_E:      kc = KC_CTRL_E;
         KEY_CTRL_K:      kc = KC_CTRL_K;
         KEY_NL:          kc = KC_NL;
         KEY_LBR:         kc = KC_LBR;
         KEY_DIGIT3:      kc = KC_DIGIT3;
         KEY_TILDE:       kc = KC_TILDE;
         KEY_UP_C:        kc = KC_RIGHT;
         KEY_UP_D:        kc = KC_LEFT;
         KEY_UP_F:        kc = KC_END;
         KEY_UP_H:        kc = KC_HOME;
         default:         kc = KC_OTHER;
      endcase
      return kc;
   endfunction

endpackage

/* rtl/tle_ctrl.sv */
module tle_ctrl
   import tle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_RDWAIT = 3'd2;
   localparam logic [2:0] S_SHL    = 3'd3;
   localparam logic [2:0] S_SHR    = 3'd4;
   localparam logic [2:0] S_PUT    = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_ESC  = 2'd1;
   localparam logic [1:0] PH_CSI  = 2'd2;
   localparam logic [1:0] PH_DEL  = 2'd3;

   logic [2:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       fin_ff, fin_in;

   assign busy = (state_ff != S_IDLE);

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      fin_in   = fin_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.mode) begin
               cmd.rd_index = 1'b1;
               state_in     = S_RDWAIT;
            end else if (fin_ff) begin
               // new key after a finished line: start empty, then re-evaluate
               cmd.clear_line = 1'b1;
               fin_in         = 1'b0;
            end else begin
               state_in = S_RESP;
               unique case (phase_ff)
                  PH_ESC: begin
                     phase_in = (sts.kclass == KC_LBR) ? PH_CSI : PH_IDLE;
                  end
                  PH_CSI: begin
                     if (sts.kclass == KC_DIGIT3) begin
                        phase_in = PH_DEL;
                     end else begin
                        phase_in = PH_IDLE;
                        case (sts.kclass)
                           KC_RIGHT: cmd.cur_inc  = sts.cur_lt_len;
                           KC_LEFT:  cmd.cur_dec  = sts.cur_nz;
                           KC_END:   cmd.cur_end  = 1'b1;
                           KC_HOME:  cmd.cur_home = 1'b1;
                           default: ;
                        endcase
                     end
                  end
                  PH_DEL: begin
                     phase_in = PH_IDLE;
                     if (sts.kclass == KC_TILDE && sts.cur_lt_len) begin
                        cmd.ptr_from_cur = 1'b1;
                        state_in         = S_SHL;
                     end
                  end
                  default: begin
                     case (sts.kclass)
                        KC_BS: begin
                           if (sts.cur_nz) begin
                              cmd.cur_dec         = 1'b1;
                              cmd.ptr_from_cur_m1 = 1'b1;
                              state_in            = S_SHL;
                           end
                        end
                        KC_ESC:    phase_in     = PH_ESC;
                        KC_CTRL_A: cmd.cur_home = 1'b1;
                        KC_CTRL_E: cmd.cur_end  = 1'b1;
                        KC_CTRL_K: cmd.len_cut  = 1'b1;
                        KC_NL: begin
                           cmd.set_done = 1'b1;
                           fin_in       = 1'b1;
                        end
                        default: begin
                           if (sts.len_lt_max) begin
                              cmd.ptr_from_len = 1'b1;
                              state_in         = S_SHR;
                           end else begin
                              cmd.set_dropped = 1'b1;
                           end
                        end
                     endcase
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            cmd.latch_char = 1'b1;
            state_in       = S_RESP;
         end
         S_SHL: begin
            if (sts.shl_more) begin
               cmd.shl_step = 1'b1;
            end else begin
               cmd.len_dec = 1'b1;
               state_in    = S_RESP;
            end
         end
         S_SHR: begin
            if (sts.shr_more) begin
               cmd.shr_step = 1'b1;
            end else begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            cmd.put_key = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_IDLE;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

/* rtl/tle_datapath.sv */
module tle_datapath
   import tle_pkg::*;
#(
   parameter int unsigned LINE_MAX = LINE_MAX_DEF
)(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int unsigned CW = $clog2(LINE_MAX + 1);
   localparam int unsigned AW = $clog2(LINE_MAX);

   req_type        req_ff;
   logic [CW-1:0]  cursor_ff, cursor_in;
   logic [CW-1:0]  length_ff, length_in;
   logic [CW-1:0]  ptr_ff, ptr_in;
   logic           wr_pend_ff;
   logic [AW-1:0]  wr_addr_ff, wr_addr_in;
   logic [7:0]     rd_data_ff;
   logic [7:0]     char_ff;
   logic           done_ff, dropped_ff;
   logic           rsp_strobe_ff;
   rsp_type        rsp_ff;

   logic [7:0]     line_mem [LINE_MAX];

   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   logic [CW:0]    ptr_p1;
   logic [CW-1:0]  ptr_m1;
   logic [CW+7:0]  idx_ext, len_ext;
   logic [CW+8:0]  cur_out, len_out;

   assign ptr_p1  = {1'b0, ptr_ff} + 1'b1;
   assign ptr_m1  = ptr_ff - 1'b1;
   assign idx_ext = {{CW{1'b0}}, req_ff.read_index};
   assign len_ext = {8'b0, length_ff};
   assign cur_out = {9'b0, cursor_ff};
   assign len_out = {9'b0, length_ff};

   // Status for the controller
   always_comb begin
      sts.mode       = req_ff.mode;
      sts.kclass     = key_class(req_ff.key_byte);
      sts.cur_lt_len = (cursor_ff < length_ff);
      sts.cur_nz     = (cursor_ff != '0);
      sts.len_lt_max = (length_ff < CW'(LINE_MAX));
      sts.shl_more   = (ptr_p1 < {1'b0, length_ff});
      sts.shr_more   = (ptr_ff > cursor_ff);
   end

   // Read address select; shift steps queue a write for the following cycle
   always_comb begin
      rd_en      = cmd.rd_index | cmd.shl_step | cmd.shr_step;
      rd_addr    = idx_ext[AW-1:0];
      wr_addr_in = ptr_ff[AW-1:0];
      if (cmd.shl_step) begin
         rd_addr = ptr_p1[AW-1:0];
      end else if (cmd.shr_step) begin
         rd_addr = ptr_m1[AW-1:0];
      end
   end

   // Line store: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         line_mem[wr_addr_ff] <= rd_data_ff;
      end else if (cmd.put_key) begin
         line_mem[cursor_ff[AW-1:0]] <= req_ff.key_byte;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   // Cursor, length and shift pointer
   always_comb begin
      cursor_in = cursor_ff;
      length_in = length_ff;
      ptr_in    = ptr_ff;
      if (cmd.clear_line) begin
         cursor_in = '0;
         length_in = '0;
      end
      if (cmd.cur_inc)  cursor_in = cursor_ff + 1'b1;
      if (cmd.cur_dec)  cursor_in = cursor_ff - 1'b1;
      if (cmd.cur_home) cursor_in = '0;
      if (cmd.cur_end)  cursor_in = length_ff;
      if (cmd.len_cut)  length_in = cursor_ff;
      if (cmd.len_dec)  length_in = length_ff - 1'b1;
      if (cmd.put_key) begin
         cursor_in = cursor_ff + 1'b1;
         length_in = length_ff + 1'b1;
      end
      if (cmd.ptr_from_cur)    ptr_in = cursor_ff;
      if (cmd.ptr_from_cur_m1) ptr_in = cursor_ff - 1'b1;
      if (cmd.ptr_from_len)    ptr_in = length_ff;
      if (cmd.shl_step)        ptr_in = ptr_p1[CW-1:0];
      if (cmd.shr_step)        ptr_in = ptr_m1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff     <= '0;
         length_ff     <= '0;
         wr_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cursor_ff     <= cursor_in;
         length_ff     <= length_in;
         wr_pend_ff    <= cmd.shl_step | cmd.shr_step;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   // Request capture, flags and result register
   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      wr_addr_ff <= wr_addr_in;
      if (cmd.load) begin
         req_ff     <= req_data;
         char_ff    <= 8'h00;
         done_ff    <= 1'b0;
         dropped_ff <= 1'b0;
      end
      if (cmd.latch_char) begin
         char_ff <= (idx_ext < len_ext) ? rd_data_ff : 8'h00;
      end
      if (cmd.set_done)    done_ff    <= 1'b1;
      if (cmd.set_dropped) dropped_ff <= 1'b1;
      if (cmd.respond) begin
         rsp_ff.cursor_pos   <= cur_out[8:0];
         rsp_ff.line_length  <= len_out[8:0];
         rsp_ff.line_done    <= done_ff;
         rsp_ff.char_dropped <= dropped_ff;
         rsp_ff.read_char    <= char_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(wr_pend_ff && cmd.put_key))
      else $error("shift write and key write in the same cycle");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= CW'(LINE_MAX))
      else $error("line length beyond capacity");

   a_cur_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= length_ff)
      else $error("cursor beyond line length");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held for two cycles");

endmodule

/* rtl/terminal_line_editor_core.sv */
// Terminal line editor. Pulse start with req_data while busy is low; one result
// follows on rsp_data, marked by rsp_strobe for a single cycle, and must be taken
// then since the receiver cannot stall the block. The first key after a finished
// line clears the line before it is handled. Backspace and delete walk the tail
// of the line one character per cycle through the line store, and an insert does
// the same in the other direction. The line store is not cleared at reset; only
// characters at positions below the line length are ever returned.
module terminal_line_editor_core
   import tle_pkg::*;
#(
   parameter int unsigned LINE_MAX = LINE_MAX_DEF
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   tle_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   tle_datapath #(
      .LINE_MAX (LINE_MAX)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

/* tb/terminal_line_editor_core_tb.sv */
`timescale 1ns / 100ps

module terminal_line_editor_core_tb;
   import tle_pkg::*;

   localparam int LINE_CAP        = LINE_MAX_DEF;
   localparam int IDX_W           = $clog2(LINE_CAP);
   localparam int REQ_W           = $bits(req_type);
   localparam int QUIET_LIMIT     = 5000;
   localparam int ITEMS_PER_PHASE = 650;

   // Escape decoder position held by the line model
   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_SEEN,
      ESC_BRACKET,
      ESC_DIGIT3
   } esc_state_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Line model state
   logic [7:0]    line_chars [LINE_CAP];
   int            cur_pos    = 0;
   int            line_len   = 0;
   esc_state_type esc_state  = ESC_NONE;
   logic          line_ended = 1'b0;

   // Responses predicted but not yet seen, oldest first
   rsp_type awaited_rsp_q [$];
   rsp_type oldest_rsp;

   int error_count     = 0;
   int keys_sent       = 0;
   int reads_sent      = 0;
   int rsp_checked     = 0;
   int drops_seen      = 0;
   int lines_done      = 0;
   int fills_done      = 0;
   int sender_idle_pct = 0;
   int quiet_cycles    = 0;

   terminal_line_editor_core #(
      .LINE_MAX(LINE_CAP)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Line model
   // ---------------------------------------------------------------

   // Close the gap left by removing the character at pos
   task automatic remove_char(input int pos);
      for (int i = pos; i + 1 < line_len; i++)
         line_chars[IDX_W'(i)] = line_chars[IDX_W'(i + 1)];
      line_len--;
   endtask

   task automatic predict_editor_response(input req_type r, output rsp_type p);
      p = '0;
      if (r.mode) begin
         if (int'(r.read_index) < line_len)
            p.read_char = line_chars[r.read_index];
      end else begin
         // first key after a finished line starts from empty
         if (line_ended) begin
            cur_pos    = 0;
            line_len   = 0;
            line_ended = 1'b0;
         end
         case (esc_state)
            ESC_SEEN: begin
               esc_state = (r.key_byte == KEY_LBR) ? ESC_BRACKET : ESC_NONE;
            end
            ESC_BRACKET: begin
               esc_state = (r.key_byte == KEY_DIGIT3) ? ESC_DIGIT3 : ESC_NONE;
               case (r.key_byte)
                  KEY_UP_C: if (cur_pos < line_len) cur_pos++;
                  KEY_UP_D: if (cur_pos > 0) cur_pos--;
                  KEY_UP_F: cur_pos = line_len;
                  KEY_UP_H: cur_pos = 0;
                  default: ;
               endcase
            end
            ESC_DIGIT3: begin
               esc_state = ESC_NONE;
               if (r.key_byte == KEY_TILDE && cur_pos < line_len)
                  remove_char(cur_pos);
            end
            default: begin
               case (r.key_byte) inside
                  KEY_BS, KEY_DEL: begin
                     if (cur_pos > 0) begin
                        cur_pos--;
                        remove_char(cur_pos);
                     end
                  end
                  KEY_ESC:    esc_state = ESC_SEEN;
                  KEY_CTRL_A: cur_pos = 0;
                  KEY_CTRL_E: cur_pos = line_len;
                  KEY_CTRL_K: line_len = cur_pos;
                  KEY_NL: begin
                     p.line_done = 1'b1;
                     line_ended  = 1'b1;
                  end
                  default: begin
                     // insert at cursor, tail moves right
                     if (line_len < LINE_CAP) begin
                        for (int i = line_len; i > cur_pos; i--)
                           line_chars[IDX_W'(i)] = line_chars[IDX_W'(i - 1)];
                        line_chars[IDX_W'(cur_pos)] = r.key_byte;
                        cur_pos++;
                        line_len++;
                     end else begin
                        p.char_dropped = 1'b1;
                     end
                  end
               endcase
            end
         endcase
      end
      p.cursor_pos  = cur_pos[8:0];
      p.line_length = line_len[8:0];
   endtask

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------

   // Present one request, hold it until taken, then log its prediction.
   // start is left high so a following request needs no re-arm.
   task automatic send_request(input req_type r);
      rsp_type p;
      int      gap;
      if ($urandom_range(99) < sender_idle_pct) begin
         gap = ($urandom_range(3) == 0) ? $urandom_range(300, 7) : $urandom_range(6, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predict_editor_response(r, p);
      awaited_rsp_q.push_back(p);
      if (r.mode) reads_sent++;
      else keys_sent++;
   endtask

   task automatic press(input logic [7:0] key);
      req_type r;
      r.mode       = 1'b0;
      r.key_byte   = key;
      r.read_index = 8'($urandom_range(255));
      send_request(r);
   endtask

   task automatic peek(input logic [7:0] idx);
      req_type r;
      r.mode       = 1'b1;
      r.key_byte   = 8'($urandom_range(255));
      r.read_index = idx;
      send_request(r);
   endtask

   task automatic csi_key(input logic [7:0] code);
      press(KEY_ESC);
      press(KEY_LBR);
      press(code);
   endtask

   task automatic csi_delete();
      press(KEY_ESC);
      press(KEY_LBR);
      press(KEY_DIGIT3);
      press(KEY_TILDE);
   endtask

   function automatic logic is_edit_key(input logic [7:0] k);
      case (k) inside
         KEY_BS, KEY_DEL, KEY_ESC, KEY_CTRL_A, KEY_CTRL_E, KEY_CTRL_K, KEY_NL:
            return 1'b1;
         default:
            return 1'b0;
      endcase
   endfunction

   // Any byte that goes into the line when no escape is pending
   function automatic logic [7:0] ordinary_key();
      logic [7:0] k;
      do k = 8'($urandom_range(255)); while (is_edit_key(k));
      return k;
   endfunction

   // Mostly inside the current line, now and then anywhere
   function automatic logic [7:0] pick_index();
      if (line_len > 0 && $urandom_range(9) < 7)
         return 8'($urandom_range(line_len - 1));
      return 8'($urandom_range(255));
   endfunction

   // Hold start low until every response is in
   task automatic wait_for_outstanding();
      start <= 1'b0;
      do @(posedge clock); while (awaited_rsp_q.size() != 0);
   endtask

   // ---------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------

   task automatic test_empty_line();
      peek(8'h00);
      peek(8'hff);
   endtask

   // Extreme byte values, both backspace codes, backspace at start
   task automatic test_insert_and_erase();
      press(8'hff);
      press(8'h00);
      press(8'h41);
      csi_key(KEY_UP_D);
      press(KEY_DEL);
      press(KEY_BS);
      press(KEY_BS);
      peek(8'h00);
      peek(8'h01);
   endtask

   // Line is one character here; arrows are pushed past both ends
   task automatic test_cursor_moves();
      csi_key(KEY_UP_D);
      press(KEY_CTRL_E);
      csi_key(KEY_UP_C);
      csi_key(KEY_UP_H);
      csi_key(KEY_UP_F);
      press(KEY_CTRL_A);
   endtask

   // Delete at cursor, delete at end of line, cut to end
   task automatic test_delete_and_cut();
      press(8'h42);
      csi_delete();
      csi_delete();
      press(KEY_CTRL_A);
      press(KEY_CTRL_K);
   endtask

   // Bytes swallowed inside an escape must not edit or end the line
   task automatic test_broken_escapes();
      press(8'h61);
      press(KEY_ESC);
      press(KEY_NL);
      csi_key(8'h41);
      press(KEY_ESC);
      press(KEY_LBR);
      press(KEY_DIGIT3);
      press(KEY_BS);
   endtask

   // Finished line stays readable until the next key clears it
   task automatic test_line_end();
      press(KEY_NL);
      peek(8'h00);
      press(8'h62);
      peek(8'h00);
   endtask

   // ---------------------------------------------------------------
   // Random editing
   // ---------------------------------------------------------------

   // Type until full, then refused inserts and full-length shifts
   task automatic fill_line();
      while (line_len < LINE_CAP || line_ended || esc_state != ESC_NONE) begin
         if ($urandom_range(31) == 0) press(KEY_CTRL_A);
         else if ($urandom_range(31) == 0) press(KEY_CTRL_E);
         else press(ordinary_key());
      end
      repeat ($urandom_range(5, 2)) press(ordinary_key());
      peek(8'hff);
      press(KEY_CTRL_A);
      csi_delete();
      press(ordinary_key());
      press(ordinary_key());
      fills_done++;
   endtask

   task automatic test_random_editing(input int idle_pct);
      int      stop_at;
      int      fill_at;
      int      kind;
      logic    filled;
      req_type r;
      sender_idle_pct = idle_pct;
      stop_at = keys_sent + reads_sent + ITEMS_PER_PHASE;
      fill_at = keys_sent + reads_sent + $urandom_range(ITEMS_PER_PHASE - 300);
      filled  = 1'b0;
      while (keys_sent + reads_sent < stop_at) begin
         kind = $urandom_range(99);
         if (!filled && keys_sent + reads_sent >= fill_at) begin
            fill_line();
            filled = 1'b1;
         end else if (kind < 30) begin
            repeat ($urandom_range(12, 1)) press(ordinary_key());
         end else if (kind < 44) begin
            case ($urandom_range(4))
               0: csi_key(KEY_UP_C);
               1: csi_key(KEY_UP_D);
               2: csi_key(KEY_UP_F);
               3: csi_key(KEY_UP_H);
               default: csi_delete();
            endcase
         end else if (kind < 54) begin
            case ($urandom_range(4))
               0: press(KEY_BS);
               1: press(KEY_DEL);
               2: press(KEY_CTRL_A);
               3: press(KEY_CTRL_E);
               default: press(KEY_CTRL_K);
            endcase
         end else if (kind < 58) begin
            press(KEY_NL);
         end else if (kind < 72) begin
            repeat ($urandom_range(4, 1)) peek(pick_index());
         end else if (kind < 82) begin
            // malformed escapes with random tails
            press(KEY_ESC);
            case ($urandom_range(2))
               0: press(8'($urandom_range(255)));
               1: begin
                  press(KEY_LBR);
                  press(8'($urandom_range(255)));
               end
               default: begin
                  press(KEY_LBR);
                  press(KEY_DIGIT3);
                  press(8'($urandom_range(255)));
               end
            endcase
         end else if (kind < 92) begin
            r = REQ_W'($urandom);
            send_request(r);
         end else begin
            // jump to the front, then type so the whole tail shifts
            if ($urandom_range(1)) press(KEY_CTRL_A);
            else csi_key(KEY_UP_H);
            repeat ($urandom_range(6, 1)) press(ordinary_key());
         end
      end
      wait_for_outstanding();
   endtask

   // ---------------------------------------------------------------
   // Response check
   // ---------------------------------------------------------------

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (awaited_rsp_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response: expected none, actual cursor %0d length %0d",
                     $time, rsp_data.cursor_pos, rsp_data.line_length);
         end else begin
            oldest_rsp = awaited_rsp_q.pop_front();
            check_field("cursor_pos", 32'(oldest_rsp.cursor_pos),
                        32'(rsp_data.cursor_pos));
            check_field("line_length", 32'(oldest_rsp.line_length),
                        32'(rsp_data.line_length));
            check_field("line_done", 32'(oldest_rsp.line_done),
                        32'(rsp_data.line_done));
            check_field("char_dropped", 32'(oldest_rsp.char_dropped),
                        32'(rsp_data.char_dropped));
            check_field("read_char", 32'(oldest_rsp.read_char),
                        32'(rsp_data.read_char));
            rsp_checked++;
            if (oldest_rsp.char_dropped) drops_seen++;
            if (oldest_rsp.line_done) lines_done++;
         end
      end
   end

   // Watchdog: stretch of cycles with neither a request nor a response
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("** terminal_line_editor_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 10;
      test_empty_line();
      test_insert_and_erase();
      test_cursor_moves();
      test_delete_and_cut();
      test_broken_escapes();
      test_line_end();
      wait_for_outstanding();

      test_random_editing(10);
      test_random_editing(68);
      test_random_editing(0);

      wait_for_outstanding();
      repeat (LINE_CAP + 16) @(posedge clock);

      $display("Covered %0d key and %0d read requests, %0d responses checked.",
               keys_sent, reads_sent, rsp_checked);
      $display("Lines ended: %0d, full-line fills: %0d, refused inserts: %0d, mismatches: %0d.",
               lines_done, fills_done, drops_seen, error_count);
      if (error_count == 0 && awaited_rsp_q.size() == 0)
         $display("** terminal_line_editor_core: PASSED **");
      else
         $display("** terminal_line_editor_core: FAILED **");
      $finish;
   end

endmodule
